/* rtl/core/bdad_pkg.sv */
package bdad_pkg;

  localparam int unsigned NUM_PLACES = 5;
  localparam int unsigned PLACE_W    = $clog2(NUM_PLACES);
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MULT_W     = 17;
  localparam int unsigned MAX_DIGIT  = 9;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [PLACE_W-1:0] LAST_PLACE = PLACE_W'(NUM_PLACES - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_t;

  typedef struct packed {
    logic last_place;
  } status_t;

  // weight of a decimal place, most significant place first
  function automatic logic [MULT_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
    logic [MULT_W-1:0] w;
    case (place)
      3'd0:    w = 17'd10000;
      3'd1:    w = 17'd1000;
      3'd2:    w = 17'd100;
      3'd3:    w = 17'd10;
      default: w = 17'd1;
    endcase
    return w;
  endfunction

  // k times the place weight, k = 0..9
  function automatic logic [MULT_W-1:0] place_mult(input logic [PLACE_W-1:0] place,
                                                   input logic [DIGIT_W-1:0] k);
    logic [MULT_W-1:0] w;
    w = place_weight(place);
    return MULT_W'(w * MULT_W'(k));
  endfunction

endpackage

/* rtl/core/bdad_ctrl.sv */
module bdad_ctrl
  import bdad_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output ctrl_t   ctrl,
  input  status_t status
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl.load = 1'b0;
    ctrl.step = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        ctrl.step = 1'b1;
        if (status.last_place) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* rtl/core/bdad_datapath.sv */
module bdad_datapath
  import bdad_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctrl,
  output status_t            status,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit
);

  logic [VALUE_W-1:0] rest_r, rest_nxt;
  logic [PLACE_W-1:0] place_r, place_nxt;
  logic [PLACE_W-1:0] first_place;
  logic [DIGIT_W-1:0] digit;
  logic [MULT_W-1:0]  digit_mult;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  // leading-zero suppression: zero keeps only the units place
  always_comb begin
    if (in_value >= 16'd10000) begin
      first_place = 3'd0;
    end else if (in_value >= 16'd1000) begin
      first_place = 3'd1;
    end else if (in_value >= 16'd100) begin
      first_place = 3'd2;
    end else if (in_value >= 16'd10) begin
      first_place = 3'd3;
    end else begin
      first_place = LAST_PLACE;
    end
  end

  // digit = largest k with k*weight <= rest; independent compares
  always_comb begin
    digit = '0;
    for (int k = 1; k <= MAX_DIGIT; k++) begin
      if ({1'b0, rest_r} >= place_mult(place_r, DIGIT_W'(k))) begin
        digit = DIGIT_W'(k);
      end
    end
  end

  assign digit_mult = place_mult(place_r, digit);

  always_comb begin
    rest_nxt  = rest_r;
    place_nxt = place_r;
    if (ctrl.load) begin
      rest_nxt  = in_value;
      place_nxt = first_place;
    end else if (ctrl.step) begin
      rest_nxt  = rest_r - digit_mult[VALUE_W-1:0];
      place_nxt = place_r + PLACE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rest_r  <= rest_nxt;
    place_r <= place_nxt;
    if (ctrl.step) begin
      out_char_r <= ASCII_ZERO + CHAR_W'(digit);
      out_last_r <= (place_r == LAST_PLACE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.step;
    end
  end

  assign status.last_place = (place_r == LAST_PLACE);
  assign out_valid         = out_valid_r;
  assign out_digit_char    = out_char_r;
  assign out_last_digit    = out_last_r;

endmodule

/* rtl/core/binary_to_decimal_ascii_digits_unit.sv */
// Channel   Ports                              Handshake
// ------    ---------------------------------  -------------------------------
// input     in_value[15:0]                     taken at edge with start & !busy
// result    out_digit_char[5:0], out_last_digit one cycle, marked by out_valid
//
// A number of N decimal digits (1 to 5, leading zeros dropped, zero gives '0')
// keeps busy high from the accepting edge until its units digit has been
// resolved; no new item is taken before busy falls. The busy time is set by
// the digit loop: one decimal place is resolved per cycle by the shared
// compare-and-subtract unit in the datapath.
// Digits appear most significant first, in the cycle after each step, each for a
// single cycle; out_last_digit marks the units digit.
// Synchronous active-low reset returns the controller to idle and clears
// out_valid. The receiver cannot stall; start is ignored while busy.
module binary_to_decimal_ascii_digits_unit
  import bdad_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit
);

  // controller <-> datapath command and status
  ctrl_t   ctrl;
  status_t status;

  // sequencer: idle, then one step per decimal place
  bdad_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .ctrl   (ctrl),
    .status (status)
  );

  // remainder, place counter, digit unit and result registers
  bdad_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .status         (status),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule
